// ===== design/jtl_pkg.sv =====
package jtl_pkg;

  localparam logic [3:0] M_IDLE = 4'd0;
  localparam logic [3:0] M_STR  = 4'd1;
  localparam logic [3:0] M_ESC  = 4'd2;
  localparam logic [3:0] M_SIGN = 4'd3;
  localparam logic [3:0] M_ZERO = 4'd4;
  localparam logic [3:0] M_INT  = 4'd5;
  localparam logic [3:0] M_DOT  = 4'd6;
  localparam logic [3:0] M_FRAC = 4'd7;
  localparam logic [3:0] M_EXPE = 4'd8;
  localparam logic [3:0] M_EXPS = 4'd9;
  localparam logic [3:0] M_EXP  = 4'd10;
  localparam logic [3:0] M_WORD = 4'd11;

  localparam logic [3:0] K_LBRACE = 4'd0;
  localparam logic [3:0] K_RBRACE = 4'd1;
  localparam logic [3:0] K_LBRACK = 4'd2;
  localparam logic [3:0] K_RBRACK = 4'd3;
  localparam logic [3:0] K_COMMA  = 4'd4;
  localparam logic [3:0] K_COLON  = 4'd5;
  localparam logic [3:0] K_STR    = 4'd6;
  localparam logic [3:0] K_NUM    = 4'd7;
  localparam logic [3:0] K_TRUE   = 4'd8;
  localparam logic [3:0] K_EOF    = 4'd11;
  localparam logic [3:0] K_ERR    = 4'd12;

  localparam logic [2:0] E_NONE    = 3'd0;
  localparam logic [2:0] E_NEWLINE = 3'd1;
  localparam logic [2:0] E_ESCAPE  = 3'd2;
  localparam logic [2:0] E_SIGN    = 3'd3;
  localparam logic [2:0] E_FRAC    = 3'd4;
  localparam logic [2:0] E_EXP     = 3'd5;
  localparam logic [2:0] E_UNKNOWN = 3'd6;

  localparam logic [1:0] W_TRUE  = 2'd0;
  localparam logic [1:0] W_FALSE = 2'd1;
  localparam logic [1:0] W_NULL  = 2'd2;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;

  typedef struct packed {
    logic [3:0] kind;
    logic       done;
    logic       tv;
    logic [7:0] text_byte;
    logic [2:0] err;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [3:0] mode;
    logic [1:0] wkind;
    logic [2:0] wpos;
    logic       wbad;
  } lex_state_t;

  typedef struct packed {
    logic       emit;
    result_t    res;
    lex_state_t st;
  } idle_t;

  typedef struct packed {
    result_t    r0;
    result_t    r1;
    logic [1:0] count;
    lex_state_t st;
  } step_t;

  function automatic result_t mk_done(logic [3:0] kind);
    result_t r;
    r = '0;
    r.kind = kind;
    r.done = 1'b1;
    return r;
  endfunction

  function automatic result_t mk_err(logic [2:0] code);
    result_t r;
    r = mk_done(K_ERR);
    r.err = code;
    return r;
  endfunction

  function automatic result_t mk_text(logic [3:0] kind, logic [7:0] b);
    result_t r;
    r = '0;
    r.kind = kind;
    r.tv = 1'b1;
    r.text_byte = b;
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  function automatic logic [2:0] kw_len(logic [1:0] k);
    logic [2:0] n;
    case (k)
      W_TRUE:  n = 3'd4;
      W_FALSE: n = 3'd5;
      W_NULL:  n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] kw_char(logic [1:0] k, logic [2:0] p);
    logic [39:0] s;
    case (k)
      W_TRUE:  s = {8'h00, "eurt"};
      W_FALSE: s = "eslaf";
      W_NULL:  s = {8'h00, "llun"};
      default: s = '0;
    endcase
    return (p < 3'd5) ? s[p*8 +: 8] : 8'h00;
  endfunction

  function automatic result_t word_finish(lex_state_t s);
    if (!s.wbad && s.wpos == kw_len(s.wkind)) begin
      return mk_done(K_TRUE + {2'b00, s.wkind});
    end
    return mk_err(E_UNKNOWN);
  endfunction

  // The first byte of a token, with the lexer otherwise idle.
  function automatic idle_t idle_byte(lex_state_t s, logic [7:0] b);
    idle_t o;
    o.emit = 1'b1;
    o.res = mk_err(E_UNKNOWN);
    o.st = s;
    o.st.mode = M_IDLE;
    case (b)
      " ", 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d: o.emit = 1'b0;
      "{": o.res = mk_done(K_LBRACE);
      "}": o.res = mk_done(K_RBRACE);
      "[": o.res = mk_done(K_LBRACK);
      "]": o.res = mk_done(K_RBRACK);
      ",": o.res = mk_done(K_COMMA);
      ":": o.res = mk_done(K_COLON);
      CH_QUOTE: begin
        o.emit = 1'b0;
        o.st.mode = M_STR;
      end
      "t", "f", "n": begin
        o.emit = 1'b0;
        o.st.mode = M_WORD;
        o.st.wkind = (b == "t") ? W_TRUE : ((b == "f") ? W_FALSE : W_NULL);
        o.st.wpos = 3'd1;
        o.st.wbad = 1'b0;
      end
      "-": begin
        o.res = mk_text(K_NUM, b);
        o.st.mode = M_SIGN;
      end
      "0": begin
        o.res = mk_text(K_NUM, b);
        o.st.mode = M_ZERO;
      end
      default: begin
        if (is_digit(b)) begin
          o.res = mk_text(K_NUM, b);
          o.st.mode = M_INT;
        end
      end
    endcase
    return o;
  endfunction

  function automatic step_t lex_step(lex_state_t s, logic [7:0] b, logic eot);
    step_t o;
    result_t a;
    result_t c;
    logic av;
    logic cv;
    idle_t id;
    logic [7:0] d;
    logic d_ok;
    a = '0;
    c = '0;
    av = 1'b0;
    cv = 1'b0;
    d = 8'h00;
    d_ok = 1'b1;
    o = '0;
    o.st = s;
    if (eot) begin
      av = 1'b1;
      case (s.mode)
        M_STR: a = mk_err(E_NEWLINE);
        M_ESC: a = mk_err(E_ESCAPE);
        M_SIGN, M_EXPS: a = mk_err(E_SIGN);
        M_DOT: a = mk_err(E_FRAC);
        M_EXPE: a = mk_err(E_EXP);
        M_ZERO, M_INT, M_FRAC, M_EXP: a = mk_done(K_NUM);
        M_WORD: a = word_finish(s);
        default: av = 1'b0;
      endcase
      cv = 1'b1;
      c = mk_done(K_EOF);
      o.st.mode = M_IDLE;
    end else begin
      av = 1'b1;
      case (s.mode)
        M_STR: begin
          if (b == CH_QUOTE) begin
            a = mk_done(K_STR);
            o.st.mode = M_IDLE;
          end else if (b == CH_LF || b == CH_CR) begin
            a = mk_err(E_NEWLINE);
            o.st.mode = M_IDLE;
          end else if (b == CH_BSL) begin
            av = 1'b0;
            o.st.mode = M_ESC;
          end else begin
            a = mk_text(K_STR, b);
          end
        end
        M_ESC: begin
          case (b)
            CH_QUOTE, CH_BSL, "/": d = b;
            "b": d = 8'd8;
            "f": d = 8'd12;
            "n": d = 8'd10;
            "r": d = 8'd13;
            "t": d = 8'd9;
            default: d_ok = 1'b0;
          endcase
          if (d_ok) begin
            a = mk_text(K_STR, d);
            o.st.mode = M_STR;
          end else begin
            a = mk_err(E_ESCAPE);
            o.st.mode = M_IDLE;
          end
        end
        M_SIGN: begin
          if (is_digit(b)) begin
            a = mk_text(K_NUM, b);
            o.st.mode = (b == "0") ? M_ZERO : M_INT;
          end else begin
            a = mk_err(E_SIGN);
            o.st.mode = M_IDLE;
          end
        end
        M_ZERO, M_INT, M_FRAC, M_EXP: begin
          if (is_digit(b) && s.mode != M_ZERO) begin
            a = mk_text(K_NUM, b);
          end else if (b == CH_DOT && (s.mode == M_ZERO || s.mode == M_INT)) begin
            a = mk_text(K_NUM, b);
            o.st.mode = M_DOT;
          end else if ((b == "e" || b == "E") && s.mode != M_EXP) begin
            a = mk_text(K_NUM, b);
            o.st.mode = M_EXPE;
          end else begin
            a = mk_done(K_NUM);
            id = idle_byte(s, b);
            cv = id.emit;
            c = id.res;
            o.st = id.st;
          end
        end
        M_DOT: begin
          if (is_digit(b)) begin
            a = mk_text(K_NUM, b);
            o.st.mode = M_FRAC;
          end else begin
            a = mk_err(E_FRAC);
            o.st.mode = M_IDLE;
          end
        end
        M_EXPE: begin
          if (is_digit(b)) begin
            a = mk_text(K_NUM, b);
            o.st.mode = M_EXP;
          end else if (b == "+" || b == "-") begin
            a = mk_text(K_NUM, b);
            o.st.mode = M_EXPS;
          end else begin
            a = mk_err(E_EXP);
            o.st.mode = M_IDLE;
          end
        end
        M_EXPS: begin
          if (is_digit(b)) begin
            a = mk_text(K_NUM, b);
            o.st.mode = M_EXP;
          end else begin
            a = mk_err(E_SIGN);
            o.st.mode = M_IDLE;
          end
        end
        M_WORD: begin
          if (is_alpha(b)) begin
            av = 1'b0;
            if (s.wpos >= kw_len(s.wkind) || kw_char(s.wkind, s.wpos) != b) begin
              o.st.wbad = 1'b1;
            end
            if (s.wpos != 3'd7) begin
              o.st.wpos = s.wpos + 3'd1;
            end
          end else begin
            a = word_finish(s);
            id = idle_byte(s, b);
            cv = id.emit;
            c = id.res;
            o.st = id.st;
          end
        end
        default: begin
          av = 1'b0;
          id = idle_byte(s, b);
          cv = id.emit;
          c = id.res;
          o.st = id.st;
        end
      endcase
    end
    if (av) begin
      o.r0 = a;
      o.r1 = c;
      o.count = cv ? 2'd2 : 2'd1;
    end else begin
      o.r0 = c;
      o.count = {1'b0, cv};
    end
    if (o.count == 2'd2) begin
      o.r1.last = 1'b1;
    end else begin
      o.r0.last = 1'b1;
    end
    return o;
  endfunction

endpackage

// ===== design/json_token_lexer.sv =====
// Result words are registered into the four-entry result queue as their byte is accepted.
// Throughput: one byte per cycle while each byte yields at most one result word and
// m_tready is high. A byte closing a number or keyword that emits a token, or an end of
// text closing a token, yields two; the queue drains them one per cycle with m_tready high.
// Reset (synchronous, active high) empties the result queue and returns the lexer to idle.
module json_token_lexer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] text_byte, [10:8] error_code, [15:11] zero
  output logic [5:0]  m_tuser,   // [3:0] token_kind, [4] token_done, [5] text_valid
  output logic        m_tlast    // last
);

  jtl_pkg::lex_state_t st;
  jtl_pkg::step_t      step;
  jtl_pkg::result_t    queue [4];
  jtl_pkg::result_t    head;
  logic [1:0]          wr_ptr;
  logic [1:0]          rd_ptr;
  logic [2:0]          count;
  logic [2:0]          count_next;
  logic                acc;
  logic                pop;

  assign step     = jtl_pkg::lex_step(st, s_tdata, s_tlast);
  assign s_tready = (count <= 3'd2);
  assign acc      = s_tvalid && s_tready;
  assign m_tvalid = (count != 3'd0);
  assign pop      = m_tvalid && m_tready;
  assign head     = queue[rd_ptr];

  assign m_tdata = {5'b00000, head.err, head.text_byte};
  assign m_tuser = {head.tv, head.done, head.kind};
  assign m_tlast = head.last;

  always_comb begin
    count_next = count;
    if (acc) begin
      count_next = count_next + {1'b0, step.count};
    end
    if (pop) begin
      count_next = count_next - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (acc) begin
        st     <= step.st;
        wr_ptr <= wr_ptr + step.count;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && step.count != 2'd0) begin
      queue[wr_ptr] <= step.r0;
    end
    if (acc && step.count == 2'd2) begin
      queue[wr_ptr + 2'd1] <= step.r1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 3'd4)
    else $error("result queue count exceeds its depth");

  a_eot_result: assert property (@(posedge clk) disable iff (rst)
    acc && s_tlast |-> step.count != 2'd0)
    else $error("end of text gave no result");

  a_eot_idle: assert property (@(posedge clk) disable iff (rst)
    acc && s_tlast |=> st.mode == jtl_pkg::M_IDLE)
    else $error("lexer not idle after end of text");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    acc && step.count != 2'd0 |=> m_tvalid)
    else $error("accepted result not offered");

endmodule
